@@ rtl/three_level_priority_queue_macros.svh @@
// Assertion helpers shared by the queue RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TLPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A trigger that must be followed by a consequence on the next clock edge.
`define TLPQ_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tlpq_pkg.sv @@
`timescale 1ns / 1ps

package tlpq_pkg;

  // Operation codes of an input transfer.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Level code that selects no queue.
  localparam logic [1:0] LEVEL_NONE = 2'd0;

  // Capacity register.
  localparam int unsigned CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam int unsigned DATA_W = 32;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_LEVEL = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Memory access request from the pointer logic to the entry store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

@@ rtl/tlpq_store.sv @@
`timescale 1ns / 1ps

module tlpq_store #(
  parameter int unsigned ENTRIES = 192,
  parameter int unsigned ADDR_W  = 8
) (
  input  logic                            clk,
  input  tlpq_pkg::mem_cmd_t              cmd,
  input  logic [ADDR_W-1:0]               addr,
  input  logic [tlpq_pkg::DATA_W-1:0]     wr_data,
  output logic [tlpq_pkg::DATA_W-1:0]     rd_data
);

  logic [tlpq_pkg::DATA_W-1:0] mem [ENTRIES];
  logic [tlpq_pkg::DATA_W-1:0] rd_data_r;

  // Single-port store: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/tlpq_ctrl.sv @@
`timescale 1ns / 1ps
`include "three_level_priority_queue_macros.svh"

module tlpq_ctrl #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          op,
  input  logic [1:0]                    level,
  input  logic [tlpq_pkg::CAP_W-1:0]    capacity,
  output tlpq_pkg::mem_cmd_t            cmd,
  output logic [ADDR_W-1:0]             addr,
  output tlpq_pkg::status_t             status,
  output logic [1:0]                    level_out
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = $clog2(2 * DEPTH);
  localparam int unsigned CMP_W = (CNT_W > tlpq_pkg::CAP_W) ? CNT_W : tlpq_pkg::CAP_W;
  localparam int unsigned TOT_W = CNT_W + 2;
  localparam logic [ADDR_W-1:0] BASE1 = ADDR_W'(DEPTH);
  localparam logic [ADDR_W-1:0] BASE2 = ADDR_W'(2 * DEPTH);

  logic [IDX_W-1:0] head_r [3];
  logic [IDX_W-1:0] head_nxt [3];
  logic [CNT_W-1:0] cnt_r [3];
  logic [CNT_W-1:0] cnt_nxt [3];

  logic [1:0]       q_sel;
  logic             any_full;
  logic             sel_full;
  logic [IDX_W-1:0] sel_head;
  logic [CNT_W-1:0] sel_cnt;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] entry_idx;
  logic [ADDR_W-1:0] base;
  logic             ins_ok;
  logic             rm_ok;
  logic [TOT_W-1:0] cnt_sum;

  // Pick the queue: the named level on insert, the first non-empty level on delete.
  always_comb begin
    any_full = (cnt_r[0] != '0) || (cnt_r[1] != '0) || (cnt_r[2] != '0);
    if (op == tlpq_pkg::OP_DELETE) begin
      priority if (cnt_r[0] != '0) begin
        q_sel = 2'd0;
      end else if (cnt_r[1] != '0) begin
        q_sel = 2'd1;
      end else begin
        q_sel = 2'd2;
      end
    end else begin
      q_sel = level - 2'd1;
    end
  end

  // Pointers of the selected queue.
  always_comb begin
    unique case (q_sel)
      2'd0: begin
        sel_head = head_r[0];
        sel_cnt  = cnt_r[0];
        base     = '0;
      end
      2'd1: begin
        sel_head = head_r[1];
        sel_cnt  = cnt_r[1];
        base     = BASE1;
      end
      2'd2: begin
        sel_head = head_r[2];
        sel_cnt  = cnt_r[2];
        base     = BASE2;
      end
      default: begin
        sel_head = '0;
        sel_cnt  = '0;
        base     = '0;
      end
    endcase
  end

  // Full when the fill reaches the capacity, which saturates at the depth.
  assign sel_full = (CMP_W'(sel_cnt) >= CMP_W'(capacity)) ||
                    (CMP_W'(sel_cnt) >= CMP_W'(DEPTH));

  // Tail and next head wrap around the circular buffer.
  always_comb begin
    tail_sum = SUM_W'(sel_head) + SUM_W'(sel_cnt);
    if (tail_sum >= SUM_W'(DEPTH)) begin
      tail_idx = IDX_W'(tail_sum - SUM_W'(DEPTH));
    end else begin
      tail_idx = IDX_W'(tail_sum);
    end
    if (sel_head == IDX_W'(DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = sel_head + IDX_W'(1);
    end
  end

  assign ins_ok    = (op == tlpq_pkg::OP_INSERT) && (level != tlpq_pkg::LEVEL_NONE) && !sel_full;
  assign rm_ok     = (op == tlpq_pkg::OP_DELETE) && any_full;
  assign entry_idx = (op == tlpq_pkg::OP_DELETE) ? sel_head : tail_idx;
  assign addr      = base + ADDR_W'(entry_idx);
  assign cmd.wr_en = accept && ins_ok;
  assign cmd.rd_en = accept && rm_ok;

  // Result status of the transfer being accepted.
  always_comb begin
    if (op == tlpq_pkg::OP_DELETE) begin
      status    = rm_ok ? tlpq_pkg::ST_REMOVED : tlpq_pkg::ST_EMPTY;
      level_out = rm_ok ? (q_sel + 2'd1) : 2'd0;
    end else begin
      level_out = 2'd0;
      priority if (level == tlpq_pkg::LEVEL_NONE) begin
        status = tlpq_pkg::ST_BAD_LEVEL;
      end else if (sel_full) begin
        status = tlpq_pkg::ST_FULL;
      end else begin
        status = tlpq_pkg::ST_INSERTED;
      end
    end
  end

  // Head and fill updates for the selected queue.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      head_nxt[i] = head_r[i];
      cnt_nxt[i]  = cnt_r[i];
      if (accept && (q_sel == 2'(i))) begin
        if (ins_ok) begin
          cnt_nxt[i] = cnt_r[i] + CNT_W'(1);
        end else if (rm_ok) begin
          cnt_nxt[i]  = cnt_r[i] - CNT_W'(1);
          head_nxt[i] = head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= head_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

  assign cnt_sum = TOT_W'(cnt_r[0]) + TOT_W'(cnt_r[1]) + TOT_W'(cnt_r[2]);

  // A successful insert adds exactly one entry overall; a removal takes one.
  `TLPQ_ASSERT_NEXT(a_insert_grows, accept && ins_ok, cnt_sum == $past(cnt_sum) + TOT_W'(1), "insert did not add one entry")
  `TLPQ_ASSERT_NEXT(a_remove_shrinks, accept && rm_ok, cnt_sum == $past(cnt_sum) - TOT_W'(1), "removal did not take one entry")
  // A failed transfer leaves every fill count alone.
  `TLPQ_ASSERT_NEXT(a_reject_holds, accept && !ins_ok && !rm_ok, cnt_sum == $past(cnt_sum), "rejected transfer changed the fill")

endmodule

@@ rtl/three_level_priority_queue.sv @@
`timescale 1ns / 1ps
`include "three_level_priority_queue_macros.svh"

// Three circular FIFO queues of signed 32-bit values, served in strict priority
// (level 1 first). A transfer is taken at an edge where start is high and busy
// is low, busy is then high for one cycle, and during that cycle the result is
// on the out_ ports with out_strobe high. The receiver cannot stall, so it must
// capture the result in that cycle. Busy is still high at the edge that ends the
// result cycle, so no new transfer is taken at that edge. The result cycle comes
// from the synchronous entry store: the head entry is read at the accepting edge
// and its registered data forms the result in the next cycle. The capacity
// register may be written only while no transfer is in flight.
module three_level_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_op,
  input  logic [1:0]                         in_priority_level,
  input  logic signed [tlpq_pkg::DATA_W-1:0] in_value_in,
  output logic                               out_strobe,
  output logic [2:0]                         out_status,
  output logic signed [tlpq_pkg::DATA_W-1:0] out_value_out,
  output logic [1:0]                         out_level_out,
  input  logic                               cfg_wr_en,
  input  logic [tlpq_pkg::CAP_W-1:0]         cfg_wr_data
);

  localparam int unsigned ENTRIES = 3 * QUEUE_DEPTH;
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);

  logic                              accept;
  logic                              busy_r;
  logic [tlpq_pkg::CAP_W-1:0]        cap_r;
  tlpq_pkg::status_t                 status_r;
  tlpq_pkg::status_t                 status_nxt;
  logic [1:0]                        level_r;
  logic [1:0]                        level_nxt;
  tlpq_pkg::mem_cmd_t                cmd;
  logic [ADDR_W-1:0]                 addr;
  logic [tlpq_pkg::DATA_W-1:0]       rd_data;

  assign accept = start && !busy_r;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= tlpq_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  tlpq_ctrl #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_op),
    .level     (in_priority_level),
    .capacity  (cap_r),
    .cmd       (cmd),
    .addr      (addr),
    .status    (status_nxt),
    .level_out (level_nxt)
  );

  tlpq_store #(
    .ENTRIES (ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_store (
    .clk     (clk),
    .cmd     (cmd),
    .addr    (addr),
    .wr_data (in_value_in),
    .rd_data (rd_data)
  );

  // Result cycle follows every accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      level_r  <= level_nxt;
    end
  end

  assign busy          = busy_r;
  assign out_strobe    = busy_r;
  assign out_status    = status_r;
  assign out_level_out = level_r;
  assign out_value_out = (status_r == tlpq_pkg::ST_REMOVED) ? rd_data : '0;

  // Each accepted transfer yields its result in the very next cycle.
  `TLPQ_ASSERT_NEXT(a_result_follows, accept, out_strobe, "accepted transfer gave no result")
  // Results never come in back-to-back cycles, since busy blocks a new transfer.
  `TLPQ_ASSERT_NEXT(a_single_result, out_strobe, !out_strobe, "result strobe held for two cycles")
  // A level is only reported together with a removal.
  `TLPQ_ASSERT(a_level_removed, !out_strobe || (out_level_out == 2'd0) || (status_r == tlpq_pkg::ST_REMOVED), "level reported without removal")

endmodule
